FILE: src/alle_pkg.sv
// Shared types and constants for the array linked list engine.
`default_nettype none
package alle_pkg;
    localparam int SLOTS  = 1024;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam int POS_W  = 11;
    localparam int VAL_W  = 32;
    localparam logic [POS_W-1:0] NULL_POS = POS_W'(SLOTS);

    typedef enum logic [2:0] {
        ACT_APPEND    = 3'd0,
        ACT_PREPEND   = 3'd1,
        ACT_INSERT    = 3'd2,
        ACT_REMOVE    = 3'd3,
        ACT_RANGE     = 3'd4,
        ACT_SEARCH    = 3'd5,
        ACT_OVERWRITE = 3'd6,
        ACT_READ      = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_POS   = 2'd1,
        ST_FULL      = 2'd2,
        ST_UNREACHED = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]              action;
        logic [POS_W-1:0]        slot;
        logic [POS_W-1:0]        range_end;
        logic signed [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] element_out;
        logic [POS_W-1:0]        position_out;
        logic [POS_W-1:0]        count;
    } t_rsp;
endpackage
`default_nettype wire

FILE: src/alle_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module alle_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]        i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [DATA_W-1:0]        o_rdata
);
    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: src/array_linked_list_engine_core.sv
// Top level of the array linked list engine: sequencer walking links through three RAMs.
// Read, overwrite and most errors finish in the check state, prepend after the take state and
// insert after the take and link states; list walks (append, remove, search, range removal)
// step through the visited slots one by one. One request at a time; busy is high until the
// result. After reset an initialization pass builds the free chain while busy is high. The
// receiver cannot stall the one-cycle strobe.
`default_nettype none
module array_linked_list_engine_core
    import alle_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_req i_req,
    output logic      o_done,
    output t_rsp      o_rsp
);
    typedef enum logic [11:0] {
        S_INIT  = 12'b000000000001,
        S_IDLE  = 12'b000000000010,
        S_CHK   = 12'b000000000100,
        S_TAKE  = 12'b000000001000,
        S_TAIL  = 12'b000000010000,
        S_LINK  = 12'b000000100000,
        S_FINDP = 12'b000001000000,
        S_GIVE  = 12'b000010000000,
        S_CHK2  = 12'b000100000000,
        S_SCAN  = 12'b001000000000,
        S_FREE  = 12'b010000000000,
        S_SRCH  = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    logic [POS_W-1:0]  r_cur, n_cur, r_slot, n_slot, r_rend, n_rend;
    logic [POS_W-1:0]  r_slink, n_slink, r_pos, n_pos, r_new, n_new;
    logic [POS_W-1:0]  r_head, n_head, r_free, n_free, r_count, n_count;
    logic [2:0]        r_act, n_act;
    logic [VAL_W-1:0]  r_val, n_val, r_elem, n_elem;
    logic [ADDR_W-1:0] r_init, n_init;
    logic              r_done, n_done;
    t_rsp              r_rsp, n_rsp;

    logic              val_we, link_we, mem_we;
    logic [ADDR_W-1:0] val_wa, link_wa, mem_wa;
    logic [VAL_W-1:0]  val_wd, val_q;
    logic [POS_W-1:0]  link_wd, link_q;
    logic              mem_wd, mem_q;

    logic             fin;
    logic [1:0]       fin_st;
    logic [VAL_W-1:0] fin_elem;
    logic [POS_W-1:0] fin_pos;
    logic             slot_ok;

    alle_ram #(.DATA_W(VAL_W), .DEPTH(SLOTS)) u_val_ram (
        .i_clk(i_clk), .i_we(val_we), .i_waddr(val_wa), .i_wdata(val_wd),
        .i_raddr(n_cur[ADDR_W-1:0]), .o_rdata(val_q)
    );
    alle_ram #(.DATA_W(POS_W), .DEPTH(SLOTS)) u_link_ram (
        .i_clk(i_clk), .i_we(link_we), .i_waddr(link_wa), .i_wdata(link_wd),
        .i_raddr(n_cur[ADDR_W-1:0]), .o_rdata(link_q)
    );
    alle_ram #(.DATA_W(1), .DEPTH(SLOTS)) u_mem_ram (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_wa), .i_wdata(mem_wd),
        .i_raddr(n_cur[ADDR_W-1:0]), .o_rdata(mem_q)
    );

    assign busy    = (r_state != S_IDLE);
    assign o_done  = r_done;
    assign o_rsp   = r_rsp;
    assign slot_ok = !r_cur[POS_W-1] && mem_q;

    always_comb begin
        n_state = r_state;
        n_cur   = r_cur;
        n_slot  = r_slot;
        n_rend  = r_rend;
        n_slink = r_slink;
        n_pos   = r_pos;
        n_new   = r_new;
        n_head  = r_head;
        n_free  = r_free;
        n_count = r_count;
        n_act   = r_act;
        n_val   = r_val;
        n_elem  = r_elem;
        n_init  = r_init;
        n_done  = 1'b0;
        n_rsp   = r_rsp;
        val_we  = 1'b0;
        val_wa  = r_cur[ADDR_W-1:0];
        val_wd  = r_val;
        link_we = 1'b0;
        link_wa = r_cur[ADDR_W-1:0];
        link_wd = NULL_POS;
        mem_we  = 1'b0;
        mem_wa  = r_cur[ADDR_W-1:0];
        mem_wd  = 1'b0;
        fin      = 1'b0;
        fin_st   = ST_OK;
        fin_elem = '0;
        fin_pos  = NULL_POS;

        unique case (r_state)
            S_INIT: begin
                link_we = 1'b1;
                link_wa = r_init;
                link_wd = {1'b0, r_init} + POS_W'(1);
                mem_we  = 1'b1;
                mem_wa  = r_init;
                n_init  = r_init + ADDR_W'(1);
                if (r_init == ADDR_W'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_act   = i_req.action;
                    n_slot  = i_req.slot;
                    n_rend  = i_req.range_end;
                    n_val   = i_req.value;
                    n_cur   = i_req.slot;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_slink = link_q;
                case (r_act)
                    ACT_APPEND, ACT_PREPEND: begin
                        if (r_free[POS_W-1]) begin
                            fin = 1'b1; fin_st = ST_FULL;
                        end else begin
                            n_cur = r_free; n_state = S_TAKE;
                        end
                    end
                    ACT_INSERT: begin
                        if (!slot_ok) begin
                            fin = 1'b1; fin_st = ST_BAD_POS;
                        end else if (r_free[POS_W-1]) begin
                            fin = 1'b1; fin_st = ST_FULL;
                        end else begin
                            n_cur = r_free; n_state = S_TAKE;
                        end
                    end
                    ACT_REMOVE: begin
                        if (!slot_ok) begin
                            fin = 1'b1; fin_st = ST_BAD_POS;
                        end else begin
                            n_elem = val_q;
                            n_pos  = link_q;
                            if (r_head == r_slot) begin
                                n_head  = link_q;
                                n_state = S_GIVE;
                            end else begin
                                n_cur   = r_head;
                                n_state = S_FINDP;
                            end
                        end
                    end
                    ACT_RANGE: begin
                        if (!slot_ok) begin
                            fin = 1'b1; fin_st = ST_BAD_POS;
                        end else begin
                            n_cur = r_rend; n_state = S_CHK2;
                        end
                    end
                    ACT_SEARCH: begin
                        n_cur = r_head; n_state = S_SRCH;
                    end
                    ACT_OVERWRITE: begin
                        if (!slot_ok) begin
                            fin = 1'b1; fin_st = ST_BAD_POS;
                        end else begin
                            val_we = 1'b1;
                            fin = 1'b1; fin_elem = val_q; fin_pos = r_slot;
                        end
                    end
                    default: begin
                        if (!slot_ok) begin
                            fin = 1'b1; fin_st = ST_BAD_POS;
                        end else begin
                            fin = 1'b1; fin_elem = val_q; fin_pos = r_slot;
                        end
                    end
                endcase
            end
            S_TAKE: begin
                n_free  = link_q;
                n_new   = r_cur;
                n_count = r_count + POS_W'(1);
                val_we  = 1'b1;
                mem_we  = 1'b1;
                mem_wd  = 1'b1;
                link_we = 1'b1;
                case (r_act)
                    ACT_PREPEND: begin
                        link_wd = r_head;
                        n_head  = r_cur;
                        fin = 1'b1; fin_pos = r_cur;
                    end
                    ACT_APPEND: begin
                        if (r_head[POS_W-1]) begin
                            n_head = r_cur;
                            fin = 1'b1; fin_pos = r_cur;
                        end else begin
                            n_cur = r_head; n_state = S_TAIL;
                        end
                    end
                    default: begin
                        link_wd = r_slink;
                        n_state = S_LINK;
                    end
                endcase
            end
            S_TAIL: begin
                if (link_q[POS_W-1]) begin
                    link_we = 1'b1;
                    link_wd = r_new;
                    fin = 1'b1; fin_pos = r_new;
                end else begin
                    n_cur = link_q;
                end
            end
            S_LINK: begin
                link_we = 1'b1;
                link_wa = r_slot[ADDR_W-1:0];
                link_wd = r_new;
                fin = 1'b1; fin_pos = r_new;
            end
            S_FINDP: begin
                if (link_q == r_slot || link_q[POS_W-1] || r_cur[POS_W-1]) begin
                    if (link_q == r_slot && !r_cur[POS_W-1]) begin
                        link_we = 1'b1;
                        link_wd = r_pos;
                    end
                    n_state = S_GIVE;
                end else begin
                    n_cur = link_q;
                end
            end
            S_GIVE: begin
                link_we = 1'b1;
                link_wa = r_slot[ADDR_W-1:0];
                link_wd = r_free;
                mem_we  = 1'b1;
                mem_wa  = r_slot[ADDR_W-1:0];
                n_free  = r_slot;
                n_count = r_count - POS_W'(1);
                fin = 1'b1; fin_elem = r_elem; fin_pos = r_pos;
            end
            S_CHK2: begin
                if (!slot_ok) begin
                    fin = 1'b1; fin_st = ST_BAD_POS;
                end else begin
                    n_cur = r_slink; n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cur == r_rend) begin
                    n_cur = r_slink; n_state = S_FREE;
                end else if (r_cur[POS_W-1]) begin
                    fin = 1'b1; fin_st = ST_UNREACHED;
                end else begin
                    n_cur = link_q;
                end
            end
            S_FREE: begin
                if (r_cur == r_rend || r_cur[POS_W-1]) begin
                    link_we = 1'b1;
                    link_wa = r_slot[ADDR_W-1:0];
                    link_wd = r_rend;
                    fin = 1'b1; fin_pos = r_rend;
                end else begin
                    link_we = 1'b1;
                    link_wd = r_free;
                    mem_we  = 1'b1;
                    n_free  = r_cur;
                    n_count = r_count - POS_W'(1);
                    n_cur   = link_q;
                end
            end
            S_SRCH: begin
                if (r_cur[POS_W-1]) begin
                    fin = 1'b1;
                end else if (val_q == r_val) begin
                    fin = 1'b1; fin_pos = r_cur;
                end else begin
                    n_cur = link_q;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_state            = S_IDLE;
            n_done             = 1'b1;
            n_rsp.status       = fin_st;
            n_rsp.element_out  = fin_elem;
            n_rsp.position_out = fin_pos;
            n_rsp.count        = n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_init  <= '0;
            r_head  <= NULL_POS;
            r_free  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
            r_cur   <= '0;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_head  <= n_head;
            r_free  <= n_free;
            r_count <= n_count;
            r_done  <= n_done;
            r_cur   <= n_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot  <= n_slot;
        r_rend  <= n_rend;
        r_slink <= n_slink;
        r_pos   <= n_pos;
        r_new   <= n_new;
        r_act   <= n_act;
        r_val   <= n_val;
        r_elem  <= n_elem;
        r_rsp   <= n_rsp;
    end
endmodule
`default_nettype wire

FILE: sim/array_linked_list_engine_core_tb.sv
// Self-checking testbench for the array linked list engine with a built-in list predictor.
`timescale 1ns / 100ps
`default_nettype none
module array_linked_list_engine_core_tb
    import alle_pkg::*;
;

    class list_scoreboard;
        logic [31:0]      vals[SLOTS];
        logic [POS_W-1:0] links[SLOTS];
        bit               used[SLOTS];
        logic [POS_W-1:0] head;
        logic [POS_W-1:0] free_head;
        int unsigned      count;
        t_rsp             pending[$];
        int               errors;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                vals[i] = '0;
                used[i] = 0;
                links[i] = POS_W'(i + 1);
            end
            head = NULL_POS;
            free_head = '0;
            count = 0;
            errors = 0;
        endfunction

        function bit is_member(logic [POS_W-1:0] p);
            return p < NULL_POS && used[p];
        endfunction

        function logic [POS_W-1:0] grab(logic [31:0] v);
            logic [POS_W-1:0] s;
            s = free_head;
            free_head = links[s];
            vals[s] = v;
            used[s] = 1;
            count++;
            return s;
        endfunction

        function void release_slot(logic [POS_W-1:0] s);
            links[s] = free_head;
            free_head = s;
            used[s] = 0;
            count--;
        endfunction

        function void note_request(t_req r);
            t_rsp e;
            logic [POS_W-1:0] cur, nxt;
            bit hit;
            e.status = ST_OK;
            e.element_out = '0;
            e.position_out = NULL_POS;
            case (t_action'(r.action))
                ACT_APPEND, ACT_PREPEND: begin
                    if (free_head >= NULL_POS) begin
                        e.status = ST_FULL;
                    end else begin
                        e.position_out = grab(r.value);
                        if (r.action == ACT_PREPEND) begin
                            links[e.position_out] = head;
                            head = e.position_out;
                        end else if (head >= NULL_POS) begin
                            links[e.position_out] = NULL_POS;
                            head = e.position_out;
                        end else begin
                            cur = head;
                            while (links[cur] < NULL_POS) cur = links[cur];
                            links[e.position_out] = NULL_POS;
                            links[cur] = e.position_out;
                        end
                    end
                end
                ACT_INSERT: begin
                    if (!is_member(r.slot)) begin
                        e.status = ST_BAD_POS;
                    end else if (free_head >= NULL_POS) begin
                        e.status = ST_FULL;
                    end else begin
                        e.position_out = grab(r.value);
                        links[e.position_out] = links[r.slot];
                        links[r.slot] = e.position_out;
                    end
                end
                ACT_REMOVE: begin
                    if (!is_member(r.slot)) begin
                        e.status = ST_BAD_POS;
                    end else begin
                        e.element_out = vals[r.slot];
                        e.position_out = links[r.slot];
                        if (head == r.slot) begin
                            head = e.position_out;
                        end else begin
                            cur = head;
                            while (cur < NULL_POS && links[cur] != r.slot) cur = links[cur];
                            if (cur < NULL_POS) links[cur] = e.position_out;
                        end
                        release_slot(r.slot);
                    end
                end
                ACT_RANGE: begin
                    if (!is_member(r.slot) || !is_member(r.range_end)) begin
                        e.status = ST_BAD_POS;
                    end else begin
                        hit = 0;
                        cur = links[r.slot];
                        while (1) begin
                            if (cur == r.range_end) begin
                                hit = 1;
                                break;
                            end
                            if (cur >= NULL_POS) break;
                            cur = links[cur];
                        end
                        if (!hit) begin
                            e.status = ST_UNREACHED;
                        end else begin
                            cur = links[r.slot];
                            while (cur != r.range_end) begin
                                nxt = links[cur];
                                release_slot(cur);
                                cur = nxt;
                            end
                            links[r.slot] = r.range_end;
                            e.position_out = r.range_end;
                        end
                    end
                end
                ACT_SEARCH: begin
                    cur = head;
                    while (cur < NULL_POS) begin
                        if (vals[cur] == r.value) begin
                            e.position_out = cur;
                            break;
                        end
                        cur = links[cur];
                    end
                end
                default: begin
                    if (!is_member(r.slot)) begin
                        e.status = ST_BAD_POS;
                    end else begin
                        e.element_out = vals[r.slot];
                        e.position_out = r.slot;
                        if (r.action == ACT_OVERWRITE) vals[r.slot] = r.value;
                    end
                end
            endcase
            e.count = POS_W'(count);
            pending.push_back(e);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h want %h", what, got, want);
            errors++;
        endtask

        task check_result(t_rsp got);
            t_rsp e;
            if (pending.size() == 0) begin
                report_mismatch("result with no request outstanding", 0, 0);
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status)
                report_mismatch("status", got.status, e.status);
            if (got.element_out !== e.element_out)
                report_mismatch("element_out", got.element_out, e.element_out);
            if (got.position_out !== e.position_out)
                report_mismatch("position_out", got.position_out, e.position_out);
            if (got.count !== e.count)
                report_mismatch("count", got.count, e.count);
        endtask

        // Pick a slot currently in the list, or null when the list is empty.
        function logic [POS_W-1:0] some_member();
            logic [POS_W-1:0] cur;
            int k;
            if (count == 0) return NULL_POS;
            k = $urandom_range(count - 1);
            cur = head;
            repeat (k) cur = links[cur];
            return cur;
        endfunction

        function logic [POS_W-1:0] member_ahead(logic [POS_W-1:0] from, int steps);
            logic [POS_W-1:0] cur;
            cur = from;
            repeat (steps) if (cur < NULL_POS) cur = links[cur];
            return cur;
        endfunction
    endclass

    localparam int IDLE_LIMIT = 20000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    t_req        i_req = '0;
    logic        o_done;
    t_rsp        o_rsp;
    list_scoreboard sb = new();
    int          gap_pct = 0;
    int          idle_cycles = 0;
    bit          timed_out = 0;

    array_linked_list_engine_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_done(o_done), .o_rsp(o_rsp)
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_rsp);
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("watchdog expired");
            $display("array_linked_list_engine_core regression: fail");
            $finish;
        end
    end

    task automatic send_request(t_action act, logic [POS_W-1:0] slot,
                                logic [POS_W-1:0] rend, logic [31:0] val);
        while ($urandom_range(99) < gap_pct) @(posedge i_clk);
        start <= 1;
        i_req <= '{action: act, slot: slot, range_end: rend, value: val};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_request(i_req);
        start <= 0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [POS_W-1:0] rand_pos();
        case ($urandom_range(9))
            0: return NULL_POS;
            1: return POS_W'($urandom_range(2047));
            2: return POS_W'($urandom_range(SLOTS - 1));
            default: return sb.some_member();
        endcase
    endfunction

    function automatic logic [31:0] rand_val();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(-1);
            3: return $urandom_range(7);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_request();
        logic [POS_W-1:0] s;
        int pick;
        pick = $urandom_range(99);
        s = rand_pos();
        if (pick < 22)
            send_request(ACT_APPEND, rand_pos(), rand_pos(), rand_val());
        else if (pick < 34)
            send_request(ACT_PREPEND, rand_pos(), rand_pos(), rand_val());
        else if (pick < 46)
            send_request(ACT_INSERT, s, rand_pos(), rand_val());
        else if (pick < 58)
            send_request(ACT_REMOVE, s, rand_pos(), rand_val());
        else if (pick < 66)
            send_request(ACT_RANGE, s,
                         $urandom_range(3) == 0 ? rand_pos()
                                                : sb.member_ahead(s, $urandom_range(1, 4)),
                         rand_val());
        else if (pick < 78)
            send_request(ACT_SEARCH, rand_pos(), rand_pos(),
                         $urandom_range(1) ? sb.vals[sb.some_member() % SLOTS] : rand_val());
        else if (pick < 89)
            send_request(ACT_OVERWRITE, s, rand_pos(), rand_val());
        else
            send_request(ACT_READ, s, rand_pos(), rand_val());
    endtask

    initial begin
        logic [POS_W-1:0] a;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Errors on an empty list, then a few elements and each action.
        send_request(ACT_READ, NULL_POS, NULL_POS, 0);
        send_request(ACT_REMOVE, 11'd0, NULL_POS, 0);
        send_request(ACT_SEARCH, 11'd0, NULL_POS, 32'h8000_0000);
        send_request(ACT_INSERT, 11'h7ff, 11'h7ff, 1);
        send_request(ACT_APPEND, 0, 0, 32'h7fff_ffff);
        send_request(ACT_APPEND, 11'h7ff, 11'h7ff, 32'h8000_0000);
        send_request(ACT_PREPEND, 0, 0, 32'hffff_ffff);
        send_request(ACT_INSERT, 11'd0, 0, 5);
        send_request(ACT_SEARCH, 0, 0, 32'h8000_0000);
        send_request(ACT_SEARCH, 0, 0, 32'd12345);
        send_request(ACT_OVERWRITE, 11'd1, 0, 32'h5555_aaaa);
        send_request(ACT_READ, 11'd1, 0, 0);
        send_request(ACT_RANGE, 11'd2, NULL_POS, 0);
        send_request(ACT_RANGE, 11'd2, 11'd0, 0);
        send_request(ACT_RANGE, 11'd2, 11'd2, 0);
        send_request(ACT_RANGE, 11'd1, 11'd3, 0);
        send_request(ACT_RANGE, 11'd2, 11'd1, 0);
        send_request(ACT_REMOVE, 11'd2, 0, 0);
        send_request(ACT_REMOVE, 11'd1, 0, 0);
        send_request(ACT_READ, 11'd1, 0, 0);
        drain();

        // Build a short list, cut most of it out by a range removal, then empty it.
        repeat (16) send_request(ACT_PREPEND, 0, 0, $urandom);
        send_request(ACT_INSERT, sb.head, 0, 2);
        a = sb.head;
        while (sb.links[a] < NULL_POS && sb.links[sb.links[a]] < NULL_POS) a = sb.links[a];
        send_request(ACT_RANGE, sb.head, a, 0);
        while (sb.count > 0) send_request(ACT_REMOVE, sb.head, 0, 0);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            gap_pct = phase == 0 ? 26 : (phase == 1 ? 82 : 0);
            repeat (83) random_request();
        end
        drain();
        repeat (2 * SLOTS + 20) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("array_linked_list_engine_core regression: pass");
        end else begin
            $display("array_linked_list_engine_core regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
